// File: hdl/scbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types and constants for the size class buffer pool unit.
// ----------------------------------------------------------------------------
package scbp_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int MAX_SLOTS   = 256;
    localparam int SIZE_W      = 20;
    localparam int COUNT_W     = 9;
    localparam int SLOT_W      = 8;
    localparam int CLASS_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int ADDR_W      = CLASS_W + SLOT_W;
    localparam int RAM_DEPTH   = NUM_CLASSES * MAX_SLOTS;

    localparam logic [CLASS_W-1:0] EXTERNAL_CLASS = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLASS0_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS1_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS2_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS0_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS1_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS2_COUNT = 3'd5;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 20'd1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd16;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_RETRY    = 3'd2,
        ST_RETURNED = 3'd3,
        ST_EXTERNAL = 3'd4,
        ST_REJECTED = 3'd5
    } t_status;

    typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0]  t_size_vec;
    typedef logic [NUM_CLASSES-1:0][COUNT_W-1:0] t_count_vec;

    typedef struct packed {
        t_status             status;
        logic [CLASS_W-1:0]  gclass;
        logic [SLOT_W-1:0]   gslot;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [SLOT_W-1:0]  wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_cmd;

    // counts above the pool depth act as the pool depth
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] lim;
        lim = COUNT_W'(MAX_SLOTS);
        return (n > lim) ? lim : n;
    endfunction

endpackage
`default_nettype wire

// File: hdl/size_class_buffer_pool_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_buffer_pool_unit
// Three-class buffer allocator with LIFO free lists of slot numbers.
// ----------------------------------------------------------------------------
// Gets and releases are answered one word per request. Most requests load their
// answer directly; a get served from a class's recycled stack first goes through
// the registered read of the stack RAM and the S_READ state. Stack pointers and
// issue counters live in flops and clear on reset, so the unit is ready right
// after reset. Configuration writes belong to idle periods only.
module size_class_buffer_pool_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [scbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [scbp_pkg::SIZE_W-1:0]      i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_req_type,
    input  wire  [scbp_pkg::SIZE_W-1:0]      i_request_size,
    input  wire                              i_wait_allowed,
    input  wire  [scbp_pkg::CLASS_W-1:0]     i_release_class,
    input  wire  [scbp_pkg::SLOT_W-1:0]      i_release_slot,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [2:0]                       o_status,
    output logic [scbp_pkg::CLASS_W-1:0]     o_granted_class,
    output logic [scbp_pkg::SLOT_W-1:0]      o_granted_slot
);

    scbp_pkg::t_size_vec              r_class_size;
    scbp_pkg::t_count_vec             r_class_count;
    logic                             r_out_valid;
    scbp_pkg::t_result                r_out;

    logic                             out_free;
    logic                             load;
    scbp_pkg::t_result                result;
    scbp_pkg::t_ram_cmd               ram_cmd;
    logic [scbp_pkg::SLOT_W-1:0]      ram_rdata;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
                r_class_size[c]  <= scbp_pkg::SIZE_RESET;
                r_class_count[c] <= scbp_pkg::COUNT_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scbp_pkg::REG_CLASS0_SIZE:  r_class_size[0]  <= i_cfg_data;
                scbp_pkg::REG_CLASS1_SIZE:  r_class_size[1]  <= i_cfg_data;
                scbp_pkg::REG_CLASS2_SIZE:  r_class_size[2]  <= i_cfg_data;
                scbp_pkg::REG_CLASS0_COUNT: r_class_count[0] <= i_cfg_data[scbp_pkg::COUNT_W-1:0];
                scbp_pkg::REG_CLASS1_COUNT: r_class_count[1] <= i_cfg_data[scbp_pkg::COUNT_W-1:0];
                scbp_pkg::REG_CLASS2_COUNT: r_class_count[2] <= i_cfg_data[scbp_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    scbp_alloc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_out_free      (out_free),
        .i_req_type      (i_req_type),
        .i_request_size  (i_request_size),
        .i_wait_allowed  (i_wait_allowed),
        .i_release_class (i_release_class),
        .i_release_slot  (i_release_slot),
        .i_class_size    (r_class_size),
        .i_class_count   (r_class_count),
        .o_ram_cmd       (ram_cmd),
        .i_ram_rdata     (ram_rdata),
        .o_load          (load),
        .o_result        (result)
    );

    scbp_stack_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_granted_class = r_out.gclass;
    assign o_granted_slot  = r_out.gslot;

endmodule
`default_nettype wire

// File: hdl/scbp_stack_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_stack_ram
// Recycled slot stacks of all classes, one write and one registered read.
// ----------------------------------------------------------------------------
module scbp_stack_ram (
    input  wire                          i_clk,
    input  wire scbp_pkg::t_ram_cmd      i_cmd,
    output logic [scbp_pkg::SLOT_W-1:0]  o_rdata
);

    logic [scbp_pkg::SLOT_W-1:0] r_mem [0:scbp_pkg::RAM_DEPTH-1];
    logic [scbp_pkg::SLOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hdl/scbp_alloc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_alloc_ctrl
// Class choice, stack pointers and issue counters; drives the stack RAM.
// ----------------------------------------------------------------------------
module scbp_alloc_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_out_free,
    input  wire                              i_req_type,
    input  wire  [scbp_pkg::SIZE_W-1:0]      i_request_size,
    input  wire                              i_wait_allowed,
    input  wire  [scbp_pkg::CLASS_W-1:0]     i_release_class,
    input  wire  [scbp_pkg::SLOT_W-1:0]      i_release_slot,
    input  wire scbp_pkg::t_size_vec         i_class_size,
    input  wire scbp_pkg::t_count_vec        i_class_count,
    output scbp_pkg::t_ram_cmd               o_ram_cmd,
    input  wire  [scbp_pkg::SLOT_W-1:0]      i_ram_rdata,
    output logic                             o_load,
    output scbp_pkg::t_result                o_result
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                          r_state, n_state;
    scbp_pkg::t_count_vec            r_fill, n_fill;
    scbp_pkg::t_count_vec            r_issued, n_issued;
    logic [scbp_pkg::CLASS_W-1:0]    r_pend_class, n_pend_class;

    scbp_pkg::t_count_vec               eff;
    logic [scbp_pkg::NUM_CLASSES-1:0]   qualifies;
    logic                               sel_found;
    logic [scbp_pkg::CLASS_W-1:0]       sel_class;
    logic                               rc_ok;
    logic [scbp_pkg::CLASS_W-1:0]       rc_idx;
    logic                               fire;
    logic [scbp_pkg::COUNT_W-1:0]       sel_fill_m1;

    assign o_in_stall = !((r_state == S_IDLE) && i_out_free);
    assign fire       = i_in_valid && !o_in_stall;

    always_comb begin
        sel_found = 1'b0;
        sel_class = '0;
        for (int c = scbp_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
            eff[c]       = scbp_pkg::eff_count(i_class_count[c]);
            qualifies[c] = (i_request_size <= i_class_size[c]) &&
                           ((r_fill[c] != '0) || (r_issued[c] < eff[c]));
            // descending scan leaves the lowest qualifying class
            if (qualifies[c]) begin
                sel_found = 1'b1;
                sel_class = scbp_pkg::CLASS_W'(c);
            end
        end
    end

    assign rc_ok       = {1'b0, i_release_class} < (scbp_pkg::CLASS_W + 1)'(scbp_pkg::NUM_CLASSES);
    assign rc_idx      = rc_ok ? i_release_class : '0;
    assign sel_fill_m1 = r_fill[sel_class] - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_issued     = r_issued;
        n_pend_class = r_pend_class;
        o_ram_cmd    = '0;
        o_load       = 1'b0;
        o_result     = '{status: scbp_pkg::ST_REJECTED, gclass: '0, gslot: '0};

        case (r_state)
            S_READ: begin
                o_load          = 1'b1;
                o_result.status = scbp_pkg::ST_GRANTED;
                o_result.gclass = r_pend_class;
                o_result.gslot  = i_ram_rdata;
                n_state         = S_IDLE;
            end
            S_IDLE: begin
                if (fire) begin
                    if (!i_req_type) begin
                        if (i_request_size > i_class_size[scbp_pkg::NUM_CLASSES-1]) begin
                            o_load          = 1'b1;
                            o_result.status = scbp_pkg::ST_OVERFLOW;
                        end else if (sel_found) begin
                            if (r_fill[sel_class] != '0) begin
                                // pop: slot comes back from the RAM next cycle
                                n_fill[sel_class] = sel_fill_m1;
                                o_ram_cmd.re      = 1'b1;
                                o_ram_cmd.raddr   = {sel_class, sel_fill_m1[scbp_pkg::SLOT_W-1:0]};
                                n_pend_class      = sel_class;
                                n_state           = S_READ;
                            end else begin
                                o_load              = 1'b1;
                                o_result.status     = scbp_pkg::ST_GRANTED;
                                o_result.gclass     = sel_class;
                                o_result.gslot      = r_issued[sel_class][scbp_pkg::SLOT_W-1:0];
                                n_issued[sel_class] = r_issued[sel_class] + 1'b1;
                            end
                        end else begin
                            o_load          = 1'b1;
                            o_result.status = i_wait_allowed ? scbp_pkg::ST_RETRY
                                                             : scbp_pkg::ST_OVERFLOW;
                        end
                    end else begin
                        o_load = 1'b1;
                        if (i_release_class == scbp_pkg::EXTERNAL_CLASS) begin
                            o_result.status = scbp_pkg::ST_EXTERNAL;
                        end else if (!rc_ok) begin
                            o_result.status = scbp_pkg::ST_REJECTED;
                        end else if (({1'b0, i_release_slot} >= eff[rc_idx]) ||
                                     (r_fill[rc_idx] >= r_issued[rc_idx])) begin
                            o_result.status = scbp_pkg::ST_REJECTED;
                        end else begin
                            o_ram_cmd.we     = 1'b1;
                            o_ram_cmd.waddr  = {rc_idx, r_fill[rc_idx][scbp_pkg::SLOT_W-1:0]};
                            o_ram_cmd.wdata  = i_release_slot;
                            n_fill[rc_idx]   = r_fill[rc_idx] + 1'b1;
                            o_result.status  = scbp_pkg::ST_RETURNED;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_issued     <= '0;
            r_pend_class <= '0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_issued     <= n_issued;
            r_pend_class <= n_pend_class;
        end
    end

endmodule
`default_nettype wire

// File: sim/scbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_checker
// Tracks the pool's free lists from the observed config writes and accepted
// requests, predicts the answer word for each request and compares it,
// field by field, with the words the unit hands out.
// ----------------------------------------------------------------------------
module scbp_checker
    import scbp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [SIZE_W-1:0]    i_cfg_data,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  wire                  i_req_type,
    input  wire  [SIZE_W-1:0]    i_request_size,
    input  wire                  i_wait_allowed,
    input  wire  [CLASS_W-1:0]   i_release_class,
    input  wire  [SLOT_W-1:0]    i_release_slot,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  wire  [2:0]           i_status,
    input  wire  [CLASS_W-1:0]   i_granted_class,
    input  wire  [SLOT_W-1:0]    i_granted_slot,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int REPORT_CAP = 100;

    logic [SIZE_W-1:0]  class_bytes    [NUM_CLASSES];
    logic [COUNT_W-1:0] class_slots    [NUM_CLASSES];
    logic [SLOT_W-1:0]  returned_slots [NUM_CLASSES][MAX_SLOTS];
    int                 returned_fill  [NUM_CLASSES];
    int                 fresh_issued   [NUM_CLASSES];
    t_result            due_answers    [$];
    int                 fails = 0;

    // slots a class may hand out; counts past the pool depth are clipped
    function automatic int usable_slots(input int c);
        int n;
        n = int'(class_slots[c]);
        return (n > MAX_SLOTS) ? MAX_SLOTS : n;
    endfunction

    function automatic t_result pool_answer(input logic rt, input logic [SIZE_W-1:0] sz,
                                            input logic wa, input logic [CLASS_W-1:0] rc,
                                            input logic [SLOT_W-1:0] rs);
        t_result r;
        int      c;
        bit      found;
        r.status = ST_OVERFLOW;
        r.gclass = '0;
        r.gslot  = '0;
        found    = 1'b0;
        if (rt == 1'b0) begin
            if (sz <= class_bytes[NUM_CLASSES-1]) begin
                r.status = wa ? ST_RETRY : ST_OVERFLOW;
                for (c = 0; c < NUM_CLASSES; c++) begin
                    if (!found && sz <= class_bytes[c] &&
                        (returned_fill[c] > 0 || fresh_issued[c] < usable_slots(c))) begin
                        found = 1'b1;
                        // recycled slots go out first, top of stack
                        if (returned_fill[c] > 0) begin
                            returned_fill[c] = returned_fill[c] - 1;
                            r.gslot = returned_slots[c][returned_fill[c]];
                        end else begin
                            r.gslot = SLOT_W'(fresh_issued[c]);
                            fresh_issued[c] = fresh_issued[c] + 1;
                        end
                        r.gclass = CLASS_W'(c);
                        r.status = ST_GRANTED;
                    end
                end
            end
        end else if (rc == EXTERNAL_CLASS) begin
            r.status = ST_EXTERNAL;
        end else if (int'(rc) >= NUM_CLASSES) begin
            r.status = ST_REJECTED;
        end else if (int'(rs) >= usable_slots(int'(rc)) ||
                     returned_fill[rc] >= fresh_issued[rc]) begin
            r.status = ST_REJECTED;
        end else begin
            returned_slots[rc][returned_fill[rc]] = rs;
            returned_fill[rc] = returned_fill[rc] + 1;
            r.status = ST_RETURNED;
        end
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int      c;
        if (!i_rst_n) begin
            for (c = 0; c < NUM_CLASSES; c++) begin
                class_bytes[c]   = SIZE_RESET;
                class_slots[c]   = COUNT_RESET;
                returned_fill[c] = 0;
                fresh_issued[c]  = 0;
            end
            due_answers.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CLASS0_SIZE:  class_bytes[0] = i_cfg_data;
                    REG_CLASS1_SIZE:  class_bytes[1] = i_cfg_data;
                    REG_CLASS2_SIZE:  class_bytes[2] = i_cfg_data;
                    REG_CLASS0_COUNT: class_slots[0] = i_cfg_data[COUNT_W-1:0];
                    REG_CLASS1_COUNT: class_slots[1] = i_cfg_data[COUNT_W-1:0];
                    REG_CLASS2_COUNT: class_slots[2] = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_answers.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_CAP)
                        $display("%0t ns: word with nothing outstanding, expected none, got %0d/%0d/%0d",
                                 $time, i_status, i_granted_class, i_granted_slot);
                end else begin
                    want = due_answers.pop_front();
                    check_field("status", 8'(want.status), 8'(i_status));
                    check_field("granted_class", 8'(want.gclass), 8'(i_granted_class));
                    check_field("granted_slot", want.gslot, i_granted_slot);
                end
            end
            if (i_in_valid && !i_in_stall)
                due_answers.push_back(pool_answer(i_req_type, i_request_size, i_wait_allowed,
                                                  i_release_class, i_release_slot));
        end
        o_fail_count <= fails;
        o_pending    <= due_answers.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives gets and releases into size_class_buffer_pool_unit over several pool
// settings, with random gaps and output back-pressure; the checker beside the
// unit predicts and compares every answer word.
// ----------------------------------------------------------------------------
module tb;
    import scbp_pkg::*;

    localparam logic REQ_GET     = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;
    localparam int   STALL_LIMIT = 2000;
    localparam int   LONG_HOLD   = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_req_type;
    logic [SIZE_W-1:0]    i_request_size;
    logic                 i_wait_allowed;
    logic [CLASS_W-1:0]   i_release_class;
    logic [SLOT_W-1:0]    i_release_slot;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_status;
    logic [CLASS_W-1:0]   o_granted_class;
    logic [SLOT_W-1:0]    o_granted_slot;

    int                        fail_count;
    int                        pending;
    int                        quiet_cycles = 0;
    bit                        rx_hold = 1'b0;
    bit                        calm = 1'b0;
    logic [SIZE_W-1:0]         cur_size [NUM_CLASSES];
    logic [CLASS_W+SLOT_W-1:0] held_bufs [$];

    size_class_buffer_pool_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_request_size  (i_request_size),
        .i_wait_allowed  (i_wait_allowed),
        .i_release_class (i_release_class),
        .i_release_slot  (i_release_slot),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_class (o_granted_class),
        .o_granted_slot  (o_granted_slot)
    );

    scbp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_request_size  (i_request_size),
        .i_wait_allowed  (i_wait_allowed),
        .i_release_class (i_release_class),
        .i_release_slot  (i_release_slot),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_granted_class (o_granted_class),
        .i_granted_slot  (o_granted_slot),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // buffers we currently hold, fed back into well-formed releases
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall && o_status == ST_GRANTED)
            held_bufs.push_back({o_granted_class, o_granted_slot});
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("size_class_buffer_pool_unit verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        bit stall_v;
        int span;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                rx_hold = 1'b0;
                stall_v = 1'b1;
                span    = LONG_HOLD;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                stall_v = 1'b1;
                span    = $urandom_range(1, 11);
            end else begin
                stall_v = 1'b0;
                span    = $urandom_range(1, 24);
            end
            i_out_stall <= stall_v;
            repeat (span) @(posedge i_clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // count writes carry junk above the 9 count bits
    task automatic set_pool(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                            input logic [SIZE_W-1:0] s2, input logic [COUNT_W-1:0] n0,
                            input logic [COUNT_W-1:0] n1, input logic [COUNT_W-1:0] n2);
        write_reg(REG_CLASS0_SIZE, s0);
        write_reg(REG_CLASS1_SIZE, s1);
        write_reg(REG_CLASS2_SIZE, s2);
        write_reg(REG_CLASS0_COUNT, {11'($urandom_range(0, 2047)), n0});
        write_reg(REG_CLASS1_COUNT, {11'($urandom_range(0, 2047)), n1});
        write_reg(REG_CLASS2_COUNT, {11'($urandom_range(0, 2047)), n2});
        i_cfg_we    <= 1'b0;
        cur_size[0] = s0;
        cur_size[1] = s1;
        cur_size[2] = s2;
    endtask

    task automatic send_word(input logic rt, input logic [SIZE_W-1:0] sz, input logic wa,
                             input logic [CLASS_W-1:0] rc, input logic [SLOT_W-1:0] rs);
        i_in_valid      <= 1'b1;
        i_req_type      <= rt;
        i_request_size  <= sz;
        i_wait_allowed  <= wa;
        i_release_class <= rc;
        i_release_slot  <= rs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_get(input logic [SIZE_W-1:0] sz, input logic wa);
        send_word(REQ_GET, sz, wa, CLASS_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 255)));
    endtask

    task automatic send_release(input logic [CLASS_W-1:0] rc, input logic [SLOT_W-1:0] rs);
        send_word(REQ_RELEASE, SIZE_W'($urandom_range(0, 20'hFFFFF)), 1'($urandom_range(0, 1)),
                  rc, rs);
    endtask

    // stop offering and wait until every answer is back
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int n, input int hold_at, input int pause_at,
                                  input int calm_from);
        int                        k;
        int                        pick;
        int                        idx;
        logic [SIZE_W-1:0]         sz;
        logic [CLASS_W+SLOT_W-1:0] buf_id;
        for (k = 0; k < n; k++) begin
            if (k == hold_at) rx_hold = 1'b1;
            if (k == pause_at) drain(0);
            if (k == calm_from) calm = 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // sizes cluster on the class boundaries
                case ($urandom_range(0, 4))
                    0:       sz = cur_size[$urandom_range(0, 2)];
                    1:       sz = cur_size[$urandom_range(0, 2)] + 1'b1;
                    2:       sz = cur_size[$urandom_range(0, 2)] - 1'b1;
                    3:       sz = SIZE_W'($urandom_range(0, 63));
                    default: sz = SIZE_W'($urandom_range(0, 20'hFFFFF));
                endcase
                send_get(sz, 1'($urandom_range(0, 1)));
            end else if (pick < 88 && held_bufs.size() != 0) begin
                idx    = $urandom_range(0, held_bufs.size() - 1);
                buf_id = held_bufs[idx];
                held_bufs.delete(idx);
                send_release(buf_id[SLOT_W +: CLASS_W], buf_id[SLOT_W-1:0]);
            end else begin
                send_release(CLASS_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [SIZE_W-1:0] s0;
        logic [SIZE_W-1:0] s1;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_req_type      = REQ_GET;
        i_request_size  = '0;
        i_wait_allowed  = 1'b0;
        i_release_class = '0;
        i_release_slot  = '0;
        cur_size[0]     = SIZE_RESET;
        cur_size[1]     = SIZE_RESET;
        cur_size[2]     = SIZE_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all classes 1024 bytes, 16 slots
        send_get(20'd0, 1'b0);
        send_get(20'd1024, 1'b1);
        send_get(20'd1025, 1'b1);
        send_get(20'hFFFFF, 1'b0);
        send_release(EXTERNAL_CLASS, 8'hFF);
        send_release(2'd0, 8'd16);          // slot past the count
        send_release(2'd1, 8'd0);           // nothing issued yet in class 1
        send_release(2'd0, 8'd1);
        send_release(2'd0, 8'd0);
        send_release(2'd0, 8'd0);           // stack already full
        send_get(20'd0, 1'b0);
        send_get(20'd512, 1'b1);
        send_get(20'd1, 1'b0);
        drain(8);

        // counts dropped below what class 0 already issued
        set_pool(20'd100, 20'd1000, 20'd100000, 9'd1, 9'd1, 9'd1);
        send_get(20'd0, 1'b1);
        send_get(20'd0, 1'b1);
        send_get(20'd0, 1'b1);              // pool exhausted, retry
        send_get(20'd0, 1'b0);              // exhausted, no waiting
        send_get(20'd100001, 1'b1);
        send_release(2'd0, 8'd2);
        send_release(2'd0, 8'd0);
        send_get(20'd50, 1'b0);
        send_release(2'd1, 8'd0);
        send_get(20'd500, 1'b1);
        send_release(2'd2, 8'd255);
        drain(8);

        set_pool(20'd0, 20'd5000, 20'hFFFFF, 9'd0, 9'd1, 9'd256);
        random_traffic(200, -1, -1, -1);
        drain(8);

        set_pool(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 9'd511, 9'd256, 9'd300);
        random_traffic(300, -1, 150, -1);
        drain(8);

        s0 = SIZE_W'($urandom_range(0, 4095));
        s1 = s0 + SIZE_W'($urandom_range(0, 65535));
        set_pool(s0, s1, SIZE_W'($urandom_range(int'(s1), 20'hFFFFF)),
                 COUNT_W'($urandom_range(1, 40)), COUNT_W'($urandom_range(1, 40)),
                 COUNT_W'($urandom_range(1, 40)));
        random_traffic(300, 60, -1, -1);
        drain(8);

        set_pool(20'd64, 20'd4096, 20'd65536, 9'd3, 9'd3, 9'd3);
        random_traffic(300, -1, -1, 150);
        drain(16);

        if (fail_count == 0)
            $display("size_class_buffer_pool_unit verification clean");
        else
            $display("size_class_buffer_pool_unit verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/scbp_pkg.sv
hdl/scbp_stack_ram.sv
hdl/scbp_alloc_ctrl.sv
hdl/size_class_buffer_pool_unit.sv
sim/scbp_checker.sv
sim/tb.sv
